// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types, constants and codes shared by the bracket balance checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

    localparam int STACK_DEPTH  = 32;
    localparam int LINE_BITS    = 16;
    localparam int STACK_ADDR_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W  = $clog2(STACK_DEPTH + 1);

    // Output item payload: error_code, bracket_kind, line_number, balanced.
    localparam int OUT_FIELD_W = 3 + 3 + LINE_BITS + 1;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_BAL_BIT = 3 + 3 + LINE_BITS;

    // Characters the lexer reacts to.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Bracket kinds; a closer is its opener plus BK_CLOSE_OFS.
    localparam logic [2:0] BK_PAREN     = 3'd0;
    localparam logic [2:0] BK_BRACE     = 3'd1;
    localparam logic [2:0] BK_BRACK     = 3'd2;
    localparam logic [2:0] BK_RPAREN    = 3'd3;
    localparam logic [2:0] BK_RBRACE    = 3'd4;
    localparam logic [2:0] BK_RBRACK    = 3'd5;
    localparam logic [2:0] BK_CLOSE_OFS = 3'd3;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_LINE_CMT,
        MODE_BLOCK_CMT,
        MODE_STRING,
        MODE_STRING_ESC,
        MODE_CHAR_OPEN,
        MODE_CHAR_ESC,
        MODE_CHAR_CLOSE
    } lex_mode_t;

    typedef enum logic [1:0] {
        RES_ERROR,
        RES_ENTRY,
        RES_VERDICT
    } res_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_OPEN_STRING,
        ERR_BAD_CHAR,
        ERR_OPEN_BLOCK,
        ERR_STACK_FULL
    } err_code_t;

    typedef struct packed {
        lex_mode_t            mode;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] cmt_line;
        logic [7:0]           held;
        logic                 pslash;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        mode:     MODE_NORMAL,
        line:     LINE_BITS'(1),
        cmt_line: '0,
        held:     '0,
        pslash:   1'b0
    };

    // What one byte does to the stack and the error stream.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 ovf;
        logic [2:0]           kind;
        logic                 err_valid;
        err_code_t            err_code;
        logic [LINE_BITS-1:0] err_line;
    } lex_act_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [LINE_BITS-1:0] line;
    } stack_entry_t;

    typedef struct packed {
        res_kind_t            kind;
        err_code_t            err_code;
        logic [2:0]           bkind;
        logic [LINE_BITS-1:0] line;
        logic                 balanced;
        logic                 last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/bbc_stack_ram.sv =====
// ----------------------------------------------------------------------------
// bbc_stack_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_stack_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 19
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_lexer.sv =====
// ----------------------------------------------------------------------------
// bbc_lexer
// Next-state decode of the lexer for one byte, with the stack action it causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_lexer
    import bbc_pkg::*;
(
    input  wire lex_state_t cur,
    input  wire logic [7:0] ch,
    input  wire logic       stack_empty,
    input  wire logic       stack_full,
    input  wire logic [2:0] top_kind,
    output      lex_state_t nxt,
    output      lex_act_t   act
);

    logic [LINE_BITS-1:0] line_inc;

    assign line_inc = (cur.line == {LINE_BITS{1'b1}}) ? cur.line : cur.line + LINE_BITS'(1);

    always_comb
    begin
        logic       handled;
        logic       is_open;
        logic       is_close;
        logic [2:0] bk;

        nxt      = cur;
        act      = '0;
        handled  = 1'b0;
        is_open  = 1'b0;
        is_close = 1'b0;
        bk       = BK_PAREN;
        act.err_line = cur.line;

        unique case (cur.mode)
            MODE_NORMAL:
            begin
                if (cur.pslash)
                begin
                    nxt.pslash = 1'b0;
                    if (ch == CH_SLASH)
                    begin
                        nxt.mode = MODE_LINE_CMT;
                        handled  = 1'b1;
                    end
                    else if (ch == CH_STAR)
                    begin
                        nxt.mode     = MODE_BLOCK_CMT;
                        nxt.cmt_line = cur.line;
                        nxt.held     = '0;
                        handled      = 1'b1;
                    end
                end
                if (!handled)
                begin
                    unique case (ch)
                        CH_NL:     nxt.line   = line_inc;
                        CH_SLASH:  nxt.pslash = 1'b1;
                        CH_DQUOTE: nxt.mode   = MODE_STRING;
                        CH_SQUOTE: nxt.mode   = MODE_CHAR_OPEN;
                        CH_LPAREN: begin is_open  = 1'b1; bk = BK_PAREN;  end
                        CH_LBRACE: begin is_open  = 1'b1; bk = BK_BRACE;  end
                        CH_LBRACK: begin is_open  = 1'b1; bk = BK_BRACK;  end
                        CH_RPAREN: begin is_close = 1'b1; bk = BK_RPAREN; end
                        CH_RBRACE: begin is_close = 1'b1; bk = BK_RBRACE; end
                        CH_RBRACK: begin is_close = 1'b1; bk = BK_RBRACK; end
                        default:   ;
                    endcase
                end
                // A closer that does not match the top is pushed like an opener.
                if (is_close && !stack_empty && (top_kind == bk - BK_CLOSE_OFS))
                begin
                    act.pop = 1'b1;
                end
                else if (is_open || is_close)
                begin
                    if (stack_full)
                    begin
                        act.ovf       = 1'b1;
                        act.err_valid = 1'b1;
                        act.err_code  = ERR_STACK_FULL;
                    end
                    else
                    begin
                        act.push = 1'b1;
                        act.kind = bk;
                    end
                end
            end
            MODE_LINE_CMT:
            begin
                if (ch == CH_NL)
                begin
                    nxt.line = line_inc;
                    nxt.mode = MODE_NORMAL;
                end
            end
            MODE_BLOCK_CMT:
            begin
                if (ch == CH_NL)
                begin
                    nxt.line = line_inc;
                end
                if (cur.held == CH_STAR && ch == CH_SLASH)
                begin
                    nxt.mode = MODE_NORMAL;
                    nxt.held = '0;
                end
                else
                begin
                    nxt.held = ch;
                end
            end
            MODE_STRING:
            begin
                if (ch == CH_NL)
                begin
                    act.err_valid = 1'b1;
                    act.err_code  = ERR_OPEN_STRING;
                    nxt.mode      = MODE_NORMAL;
                    nxt.line      = line_inc;
                end
                else if (ch == CH_BSLASH)
                begin
                    nxt.mode = MODE_STRING_ESC;
                end
                else if (ch == CH_DQUOTE)
                begin
                    nxt.mode = MODE_NORMAL;
                end
            end
            MODE_STRING_ESC:
            begin
                if (ch == CH_NL)
                begin
                    nxt.line = line_inc;
                end
                nxt.mode = MODE_STRING;
            end
            MODE_CHAR_OPEN:
            begin
                if (ch == CH_NL || ch == CH_SQUOTE)
                begin
                    act.err_valid = 1'b1;
                    act.err_code  = ERR_BAD_CHAR;
                    nxt.mode      = MODE_NORMAL;
                    if (ch == CH_NL)
                    begin
                        nxt.line = line_inc;
                    end
                end
                else if (ch == CH_BSLASH)
                begin
                    nxt.mode = MODE_CHAR_ESC;
                end
                else
                begin
                    nxt.mode = MODE_CHAR_CLOSE;
                end
            end
            MODE_CHAR_ESC:
            begin
                if (ch == CH_NL)
                begin
                    act.err_valid = 1'b1;
                    act.err_code  = ERR_BAD_CHAR;
                    nxt.mode      = MODE_NORMAL;
                    nxt.line      = line_inc;
                end
                else
                begin
                    nxt.mode = MODE_CHAR_CLOSE;
                end
            end
            MODE_CHAR_CLOSE:
            begin
                nxt.mode = MODE_NORMAL;
                if (ch != CH_SQUOTE)
                begin
                    act.err_valid = 1'b1;
                    act.err_code  = ERR_BAD_CHAR;
                    if (ch == CH_NL)
                    begin
                        nxt.line = line_inc;
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bbc_out_fifo
// Two-entry result queue that decouples the lexer from the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_out_fifo
    import bbc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output      logic    room,
    output      logic    out_valid,
    input  wire logic    out_ready,
    output      result_t out_data
);

    result_t    entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;

    assign room      = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_balance_checker: one text byte per cycle while the result queue has room; results are
// registered in the output queue. The end-of-text dump reads each stack entry through the RAM's
// single read port in ST_DUMP_RD and queues it in ST_DUMP_WR, then adds one verdict.
// Input is held off from the last byte until the verdict is queued.
// Reset (rst_n low, asynchronous) empties the stack and starts counting lines at one.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input stream.
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] char_in
    input  wire logic                  s_tlast,   // end_of_text
    // Result stream.
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    output      logic [OUT_DATA_W-1:0] m_tdata,   // error_code, bracket_kind,
                                                  // line_number, balanced, zero pad
    output      logic [1:0]            m_tuser,   // [1:0] result_kind
    output      logic                  m_tlast    // last_result
);

    // The sequencer either streams text bytes through the lexer, or walks
    // the stack from the top down to report leftovers, then emits the verdict.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DUMP_RD,
        ST_DUMP_WR,
        ST_VERDICT
    } state_t;

    state_t                 state_reg;
    lex_state_t             lex_reg;
    logic [STACK_CNT_W-1:0] count_reg;
    logic [STACK_CNT_W-1:0] count_next;
    logic [STACK_CNT_W-1:0] idx_reg;
    logic                   ovf_reg;
    logic                   ovf_next;
    // Top of stack is held in flops after a push, and taken from the RAM
    // read register after a pop (the pop itself issues that read).
    stack_entry_t           top_reg;
    logic                   top_from_ram_reg;

    lex_state_t             lex_nxt;
    lex_act_t               act;
    stack_entry_t           top_entry;
    stack_entry_t           ram_rdata;
    logic [$bits(stack_entry_t)-1:0] ram_rdata_raw;
    logic                   ram_we;
    logic                   ram_re;
    logic [STACK_ADDR_W-1:0] ram_raddr;
    logic                   stack_empty;
    logic                   stack_full;

    logic                   accept;
    logic                   lex_go;
    logic                   fifo_room;
    logic                   fifo_push;
    result_t                fifo_in;
    result_t                fifo_out;
    result_t                item_res;
    logic                   item_res_valid;

    assign ram_rdata   = stack_entry_t'(ram_rdata_raw);
    assign top_entry   = top_from_ram_reg ? ram_rdata : top_reg;
    assign stack_empty = (count_reg == '0);
    assign stack_full  = (count_reg == STACK_CNT_W'(STACK_DEPTH));

    // In the run state a byte is taken whenever the result queue has a free slot, so one
    // waiting result never stalls the text stream.
    assign s_tready = (state_reg == ST_RUN) && fifo_room;
    assign accept   = s_tvalid && s_tready;
    // After a stack overflow the text is ignored until its last byte.
    assign lex_go   = accept && !ovf_reg;

    bbc_lexer u_lexer (
        .cur         (lex_reg),
        .ch          (s_tdata),
        .stack_empty (stack_empty),
        .stack_full  (stack_full),
        .top_kind    (top_entry.kind),
        .nxt         (lex_nxt),
        .act         (act)
    );

    assign ram_we = lex_go && act.push;

    // Read port: below-the-top entry on a pop, or the entry under the dump index.
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = '0;
        if (state_reg == ST_RUN)
        begin
            ram_re    = lex_go && act.pop;
            ram_raddr = STACK_ADDR_W'(count_reg - STACK_CNT_W'(2));
        end
        else if (state_reg == ST_DUMP_RD)
        begin
            ram_re    = (idx_reg != '0);
            ram_raddr = STACK_ADDR_W'(idx_reg - STACK_CNT_W'(1));
        end
    end

    bbc_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH ($bits(stack_entry_t))
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (STACK_ADDR_W'(count_reg)),
        .wdata ({act.kind, lex_reg.line}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (lex_go)
        begin
            if (act.push)
            begin
                count_next = count_reg + STACK_CNT_W'(1);
            end
            else if (act.pop)
            begin
                count_next = count_reg - STACK_CNT_W'(1);
            end
            if (act.ovf)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    // Result of a text byte: a lexing error, or on the last byte an error for
    // an unfinished string, char literal or block comment. One byte never
    // causes both, since a lexing error always leaves normal mode or overflow.
    always_comb
    begin
        item_res       = '0;
        item_res.kind  = RES_ERROR;
        item_res_valid = 1'b0;
        if (lex_go && act.err_valid)
        begin
            item_res_valid    = 1'b1;
            item_res.err_code = act.err_code;
            item_res.line     = act.err_line;
        end
        else if (s_tlast && !ovf_next)
        begin
            priority if (lex_nxt.mode == MODE_STRING || lex_nxt.mode == MODE_STRING_ESC)
            begin
                item_res_valid    = 1'b1;
                item_res.err_code = ERR_OPEN_STRING;
                item_res.line     = lex_nxt.line;
            end
            else if (lex_nxt.mode == MODE_CHAR_OPEN || lex_nxt.mode == MODE_CHAR_ESC ||
                     lex_nxt.mode == MODE_CHAR_CLOSE)
            begin
                item_res_valid    = 1'b1;
                item_res.err_code = ERR_BAD_CHAR;
                item_res.line     = lex_nxt.line;
            end
            else if (lex_nxt.mode == MODE_BLOCK_CMT)
            begin
                item_res_valid    = 1'b1;
                item_res.err_code = ERR_OPEN_BLOCK;
                item_res.line     = lex_nxt.cmt_line;
            end
        end
    end

    // Queue input: text results, dumped entries, then the verdict.
    always_comb
    begin
        fifo_in   = '0;
        fifo_push = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                fifo_in   = item_res;
                fifo_push = accept && item_res_valid;
            end
            ST_DUMP_WR:
            begin
                fifo_in.kind  = RES_ENTRY;
                fifo_in.bkind = ram_rdata.kind;
                fifo_in.line  = ram_rdata.line;
                fifo_push     = fifo_room;
            end
            ST_VERDICT:
            begin
                fifo_in.kind     = RES_VERDICT;
                fifo_in.balanced = stack_empty && !ovf_reg;
                fifo_in.last     = 1'b1;
                fifo_push        = fifo_room;
            end
            ST_DUMP_RD: ;
        endcase
    end

    bbc_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (fifo_in),
        .room      (fifo_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out)
    );

    assign m_tdata = OUT_DATA_W'({fifo_out.balanced, fifo_out.line, fifo_out.bkind,
                                  fifo_out.err_code});
    assign m_tuser = fifo_out.kind;
    assign m_tlast = fifo_out.last;

    // Sequencer and stack bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_RUN;
            lex_reg          <= LEX_RESET;
            count_reg        <= '0;
            idx_reg          <= '0;
            ovf_reg          <= 1'b0;
            top_from_ram_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    if (lex_go)
                    begin
                        lex_reg <= lex_nxt;
                        if (act.push)
                        begin
                            top_from_ram_reg <= 1'b0;
                        end
                        else if (act.pop)
                        begin
                            top_from_ram_reg <= 1'b1;
                        end
                    end
                    count_reg <= count_next;
                    ovf_reg   <= ovf_next;
                    if (accept && s_tlast)
                    begin
                        idx_reg   <= count_next;
                        state_reg <= ST_DUMP_RD;
                    end
                end
                ST_DUMP_RD:
                begin
                    // Entries are listed top first; an empty index ends the walk.
                    if (idx_reg == '0)
                    begin
                        state_reg <= ST_VERDICT;
                    end
                    else
                    begin
                        state_reg <= ST_DUMP_WR;
                    end
                end
                ST_DUMP_WR:
                begin
                    if (fifo_room)
                    begin
                        idx_reg   <= idx_reg - STACK_CNT_W'(1);
                        state_reg <= ST_DUMP_RD;
                    end
                end
                ST_VERDICT:
                begin
                    // Once the verdict is queued the block is ready for a new text.
                    if (fifo_room)
                    begin
                        lex_reg          <= LEX_RESET;
                        count_reg        <= '0;
                        ovf_reg          <= 1'b0;
                        top_from_ram_reg <= 1'b0;
                        state_reg        <= ST_RUN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            top_reg <= {act.kind, lex_reg.line};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level assertions for the bracket balance checker, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bbc_checker
    import bbc_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [7:0]            s_tdata,
    input wire logic                  s_tlast,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [1:0]            m_tuser,
    input wire logic                  m_tlast
);

    logic s_accept;

    assign s_accept = s_tvalid && s_tready && (s_tdata == s_tdata);

    // A result that is not taken stays on the bus unchanged.
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // The last byte of a text starts the dump; no byte is taken next cycle.
    `ASSERT_CLK(a_dump_blocks, clk, rst_n, s_accept && s_tlast |=> !s_tready, "input taken during dump")

    // Only the verdict closes a run, and every verdict does.
    `ASSERT_IMPLY(a_last_is_verdict, clk, rst_n, m_tvalid, m_tlast == (m_tuser == RES_VERDICT), "tlast does not match verdict")

    // Leftover entries never claim a balanced text.
    `ASSERT_IMPLY(a_entry_unbalanced, clk, rst_n, m_tvalid && m_tuser == RES_ENTRY, !m_tdata[OUT_BAL_BIT], "entry with balanced set")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for bracket_balance_checker
// Streams short source texts into the checker and compares every result item
// with an in-bench scanner that tracks lexer mode, line count and bracket stack.
// ----------------------------------------------------------------------------

module tb
    import bbc_pkg::*;
;

    // One planned input item. A nonzero n_want means the listed results were
    // typed in by hand and replace what the scanner predicts for this item.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic [1:0] n_want;
        result_t    want0;
        result_t    want1;
    } step_t;

    localparam result_t NO_RESULT = '0;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // Idling on both sides is switched off for one stretch of the run.
    bit gaps_on = 1'b1;
    int error_count = 0;

    step_t      plan [25];
    step_t      item_notes [$];   // one note per item driven, popped on acceptance
    result_t    awaited [$];      // results still owed by the checker
    result_t    scan_out [$];     // results of the byte just scanned
    logic [7:0] text [$];         // text being composed for the next run

    // Scanner state, mirroring the checker's lexer and bracket stack.
    stack_entry_t         held_stack [STACK_DEPTH];
    int                   held_count;
    lex_mode_t            scan_mode;
    logic [LINE_BITS-1:0] scan_line;
    logic [LINE_BITS-1:0] open_cmt_line;
    logic [7:0]           cmt_prev;
    logic                 slash_seen;
    logic                 stack_blown;

    bracket_balance_checker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scanner: works out the results that each text byte causes.
    // ------------------------------------------------------------------------
    function automatic result_t make_result(res_kind_t k, err_code_t e, logic [2:0] bk,
                                            logic [LINE_BITS-1:0] ln, logic bal, logic lst);
        return '{kind: k, err_code: e, bkind: bk, line: ln, balanced: bal, last: lst};
    endfunction

    function automatic void restart_scanner();
        held_count    = 0;
        scan_mode     = MODE_NORMAL;
        scan_line     = 1;
        open_cmt_line = '0;
        cmt_prev      = 8'h00;
        slash_seen    = 1'b0;
        stack_blown   = 1'b0;
    endfunction

    // The line count saturates instead of wrapping.
    function automatic void count_line();
        if (scan_line != '1)
            scan_line = scan_line + 1'b1;
    endfunction

    function automatic void push_bracket(logic [2:0] k);
        if (held_count >= STACK_DEPTH)
        begin
            stack_blown = 1'b1;
            scan_out.push_back(make_result(RES_ERROR, ERR_STACK_FULL, '0, scan_line, 0, 0));
        end
        else
        begin
            held_stack[held_count] = '{kind: k, line: scan_line};
            held_count++;
        end
    endfunction

    // A closer that does not match the top of the stack is pushed itself.
    function automatic void close_bracket(logic [2:0] k);
        if (held_count > 0 && held_stack[held_count - 1].kind == k - BK_CLOSE_OFS)
            held_count--;
        else
            push_bracket(k);
    endfunction

    function automatic void bad_literal(logic [7:0] ch);
        scan_out.push_back(make_result(RES_ERROR, ERR_BAD_CHAR, '0, scan_line, 0, 0));
        scan_mode = MODE_NORMAL;
        if (ch == CH_NL)
            count_line();
    endfunction

    function automatic void scan_byte(logic [7:0] ch, logic eot);
        int i;
        // After a stack overflow every byte is ignored until the end of the text.
        if (!stack_blown)
        begin
            case (scan_mode)
                MODE_NORMAL:
                begin
                    if (slash_seen && ch == CH_SLASH)
                    begin
                        slash_seen = 1'b0;
                        scan_mode  = MODE_LINE_CMT;
                    end
                    else if (slash_seen && ch == CH_STAR)
                    begin
                        slash_seen    = 1'b0;
                        scan_mode     = MODE_BLOCK_CMT;
                        open_cmt_line = scan_line;
                        cmt_prev      = 8'h00;
                    end
                    else
                    begin
                        // A lone slash is dropped and this byte is taken as usual.
                        slash_seen = 1'b0;
                        case (ch)
                            CH_NL:     count_line();
                            CH_SLASH:  slash_seen = 1'b1;
                            CH_DQUOTE: scan_mode = MODE_STRING;
                            CH_SQUOTE: scan_mode = MODE_CHAR_OPEN;
                            CH_LPAREN: push_bracket(BK_PAREN);
                            CH_LBRACE: push_bracket(BK_BRACE);
                            CH_LBRACK: push_bracket(BK_BRACK);
                            CH_RPAREN: close_bracket(BK_RPAREN);
                            CH_RBRACE: close_bracket(BK_RBRACE);
                            CH_RBRACK: close_bracket(BK_RBRACK);
                            default:   ;
                        endcase
                    end
                end
                MODE_LINE_CMT:
                begin
                    if (ch == CH_NL)
                    begin
                        count_line();
                        scan_mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK_CMT:
                begin
                    if (ch == CH_NL)
                        count_line();
                    if (cmt_prev == CH_STAR && ch == CH_SLASH)
                    begin
                        scan_mode = MODE_NORMAL;
                        cmt_prev  = 8'h00;
                    end
                    else
                        cmt_prev = ch;
                end
                MODE_STRING:
                begin
                    if (ch == CH_NL)
                    begin
                        scan_out.push_back(make_result(RES_ERROR, ERR_OPEN_STRING, '0,
                                                       scan_line, 0, 0));
                        scan_mode = MODE_NORMAL;
                        count_line();
                    end
                    else if (ch == CH_BSLASH)
                        scan_mode = MODE_STRING_ESC;
                    else if (ch == CH_DQUOTE)
                        scan_mode = MODE_NORMAL;
                end
                MODE_STRING_ESC:
                begin
                    // An escaped newline continues the string on the next line.
                    if (ch == CH_NL)
                        count_line();
                    scan_mode = MODE_STRING;
                end
                MODE_CHAR_OPEN:
                begin
                    if (ch == CH_NL || ch == CH_SQUOTE)
                        bad_literal(ch);
                    else if (ch == CH_BSLASH)
                        scan_mode = MODE_CHAR_ESC;
                    else
                        scan_mode = MODE_CHAR_CLOSE;
                end
                MODE_CHAR_ESC:
                begin
                    if (ch == CH_NL)
                        bad_literal(ch);
                    else
                        scan_mode = MODE_CHAR_CLOSE;
                end
                default:
                begin
                    if (ch == CH_SQUOTE)
                        scan_mode = MODE_NORMAL;
                    else
                        bad_literal(ch);
                end
            endcase
        end

        if (eot)
        begin
            if (!stack_blown)
            begin
                if (scan_mode == MODE_STRING || scan_mode == MODE_STRING_ESC)
                    scan_out.push_back(make_result(RES_ERROR, ERR_OPEN_STRING, '0,
                                                   scan_line, 0, 0));
                else if (scan_mode >= MODE_CHAR_OPEN)
                    scan_out.push_back(make_result(RES_ERROR, ERR_BAD_CHAR, '0,
                                                   scan_line, 0, 0));
                else if (scan_mode == MODE_BLOCK_CMT)
                    scan_out.push_back(make_result(RES_ERROR, ERR_OPEN_BLOCK, '0,
                                                   open_cmt_line, 0, 0));
            end
            // Leftover brackets come out top first, then the verdict.
            for (i = held_count; i > 0; i--)
                scan_out.push_back(make_result(RES_ENTRY, ERR_NONE, held_stack[i - 1].kind,
                                               held_stack[i - 1].line, 0, 0));
            scan_out.push_back(make_result(RES_VERDICT, ERR_NONE, '0, '0,
                                           held_count == 0 && !stack_blown, 1));
            restart_scanner();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard. Results are checked before the accepted byte is scanned, so
    // the order of the two never depends on scheduling within a time step.
    // ------------------------------------------------------------------------
    task automatic flag_error(input string what);
        $display("tb: mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        result_t got;
        result_t want;
        step_t   note;
        string   bad;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{kind:     res_kind_t'(m_tuser),
                        err_code: err_code_t'(m_tdata[2:0]),
                        bkind:    m_tdata[5:3],
                        line:     m_tdata[6 +: LINE_BITS],
                        balanced: m_tdata[OUT_BAL_BIT],
                        last:     m_tlast};
                if (awaited.size() == 0)
                    flag_error($sformatf("result with nothing awaited: kind %0d line %0d",
                                         got.kind, got.line));
                else
                begin
                    want = awaited.pop_front();
                    bad = "";
                    if (got.kind !== want.kind)
                        bad = {bad, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
                    if (got.err_code !== want.err_code)
                        bad = {bad, $sformatf(" error %0d/%0d", got.err_code, want.err_code)};
                    if (got.bkind !== want.bkind)
                        bad = {bad, $sformatf(" bracket %0d/%0d", got.bkind, want.bkind)};
                    if (got.line !== want.line)
                        bad = {bad, $sformatf(" line %0d/%0d", got.line, want.line)};
                    if (got.balanced !== want.balanced)
                        bad = {bad, $sformatf(" balanced %0d/%0d", got.balanced,
                                              want.balanced)};
                    if (got.last !== want.last)
                        bad = {bad, $sformatf(" last %0d/%0d", got.last, want.last)};
                    if (bad != "")
                        flag_error({"result fields got/want:", bad});
                end
            end
            if (s_tvalid && s_tready)
            begin
                note = item_notes.pop_front();
                scan_out.delete();
                scan_byte(s_tdata, s_tlast);
                if (note.n_want == 2'd0)
                    foreach (scan_out[i])
                        awaited.push_back(scan_out[i]);
                else
                begin
                    awaited.push_back(note.want0);
                    if (note.n_want == 2'd2)
                        awaited.push_back(note.want1);
                end
            end
        end
    end

    // Result side: stalls with a chance of about 17 in 100 while idling is on.
    always @(posedge clk)
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= 17);

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input step_t st);
        item_notes.push_back(st);
        while (gaps_on && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= st.ch;
        s_tlast  <= st.eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        int k;
        for (k = 0; k < text.size(); k++)
            send_item('{text[k], k == text.size() - 1, 2'd0, NO_RESULT, NO_RESULT});
    endtask

    // Holds the input off until every owed result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] bracket_char(int k);
        case (k)
            0:       return CH_LPAREN;
            1:       return CH_LBRACE;
            2:       return CH_LBRACK;
            3:       return CH_RPAREN;
            4:       return CH_RBRACE;
            default: return CH_RBRACK;
        endcase
    endfunction

    // Mostly lowercase letters, often a byte the lexer reacts to, sometimes any byte.
    function automatic logic [7:0] filler();
        case ($urandom_range(0, 3))
            0, 1: return 8'($urandom_range(8'h61, 8'h7A));
            2:    return 8'($urandom_range(0, 255));
            default:
                case ($urandom_range(0, 5))
                    0:       return CH_STAR;
                    1:       return CH_SLASH;
                    2:       return CH_BSLASH;
                    3:       return CH_SQUOTE;
                    4:       return CH_DQUOTE;
                    default: return CH_NL;
                endcase
        endcase
    endfunction

    // Builds a text from tokens: brackets that mostly nest properly, strings,
    // char literals, comments, newlines, lone slashes and raw noise. A few
    // tokens are deliberately broken.
    task automatic compose_text(input int tokens);
        int         open_kinds [$];
        int         pick;
        int         k;
        logic [7:0] c;
        text.delete();
        repeat (tokens)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
            begin
                k = $urandom_range(0, 2);
                open_kinds.push_back(k);
                text.push_back(bracket_char(k));
            end
            else if (pick < 32)
            begin
                if (open_kinds.size() != 0 && $urandom_range(0, 4) != 0)
                    text.push_back(bracket_char(open_kinds.pop_back() + 3));
                else
                    text.push_back(bracket_char($urandom_range(3, 5)));
            end
            else if (pick < 42)
            begin
                text.push_back(CH_DQUOTE);
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(0, 4) == 0)
                    begin
                        text.push_back(CH_BSLASH);
                        text.push_back(filler());
                    end
                    else
                    begin
                        c = filler();
                        if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_NL)
                            c = 8'h78;
                        text.push_back(c);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    text.push_back(CH_DQUOTE);
            end
            else if (pick < 50)
            begin
                text.push_back(CH_SQUOTE);
                if ($urandom_range(0, 6) == 0)
                begin
                    // Broken literal: empty, too long, or cut by a newline.
                    case ($urandom_range(0, 2))
                        0:       text.push_back(CH_SQUOTE);
                        1:       begin text.push_back(8'h61); text.push_back(8'h62); end
                        default: text.push_back(CH_NL);
                    endcase
                end
                else
                begin
                    c = filler();
                    if ($urandom_range(0, 3) == 0)
                    begin
                        text.push_back(CH_BSLASH);
                        if (c == CH_NL)
                            c = 8'h6E;
                    end
                    else if (c == CH_NL || c == CH_SQUOTE || c == CH_BSLASH)
                        c = 8'h61;
                    text.push_back(c);
                    text.push_back(CH_SQUOTE);
                end
            end
            else if (pick < 56)
            begin
                text.push_back(CH_SLASH);
                text.push_back(CH_SLASH);
                repeat ($urandom_range(0, 4))
                begin
                    c = filler();
                    text.push_back(c == CH_NL ? 8'h61 : c);
                end
                text.push_back(CH_NL);
            end
            else if (pick < 62)
            begin
                text.push_back(CH_SLASH);
                text.push_back(CH_STAR);
                repeat ($urandom_range(0, 5))
                    text.push_back(filler());
                if ($urandom_range(0, 9) != 0)
                begin
                    text.push_back(CH_STAR);
                    text.push_back(CH_SLASH);
                end
            end
            else if (pick < 72)
                text.push_back(CH_NL);
            else if (pick < 80)
            begin
                text.push_back(CH_SLASH);
                text.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                                    : bracket_char($urandom_range(0, 5)));
            end
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Rows with typed results are the ones whose outcome is
    // plain from the rules; the rest are left to the scanner.
    // ------------------------------------------------------------------------
    initial
    begin
        restart_scanner();
        // A lone closer makes a whole text: it is left on the stack.
        plan[0]  = '{CH_RPAREN, 1'b1, 2'd2,
                     make_result(RES_ENTRY, ERR_NONE, BK_RPAREN, 1, 0, 0),
                     make_result(RES_VERDICT, ERR_NONE, '0, 0, 0, 1)};
        // Text ends inside a string, then inside a char literal.
        plan[1]  = '{CH_DQUOTE, 1'b1, 2'd2,
                     make_result(RES_ERROR, ERR_OPEN_STRING, '0, 1, 0, 0),
                     make_result(RES_VERDICT, ERR_NONE, '0, 0, 1, 1)};
        plan[2]  = '{CH_SQUOTE, 1'b1, 2'd2,
                     make_result(RES_ERROR, ERR_BAD_CHAR, '0, 1, 0, 0),
                     make_result(RES_VERDICT, ERR_NONE, '0, 0, 1, 1)};
        // Text ends inside a block comment.
        plan[3]  = '{CH_SLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[4]  = '{CH_STAR, 1'b1, 2'd2,
                     make_result(RES_ERROR, ERR_OPEN_BLOCK, '0, 1, 0, 0),
                     make_result(RES_VERDICT, ERR_NONE, '0, 0, 1, 1)};
        // Lowest byte value, then an empty char literal.
        plan[5]  = '{8'h00, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[6]  = '{CH_SQUOTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[7]  = '{CH_SQUOTE, 1'b0, 2'd1,
                     make_result(RES_ERROR, ERR_BAD_CHAR, '0, 1, 0, 0), NO_RESULT};
        plan[8]  = '{CH_LPAREN, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[9]  = '{CH_NL, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        // String continued over a newline by a backslash, then cut by a bare newline.
        plan[10] = '{CH_DQUOTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[11] = '{CH_BSLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[12] = '{CH_NL, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[13] = '{CH_NL, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        // Escaped quote as a char literal.
        plan[14] = '{CH_SQUOTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[15] = '{CH_BSLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[16] = '{CH_SQUOTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[17] = '{CH_SQUOTE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        // A bracket inside a line comment is not counted.
        plan[18] = '{CH_SLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[19] = '{CH_SLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[20] = '{CH_LBRACE, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[21] = '{CH_NL, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        // Lone slash: the following closer is handled as usual.
        plan[22] = '{CH_SLASH, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[23] = '{CH_RBRACK, 1'b0, 2'd0, NO_RESULT, NO_RESULT};
        plan[24] = '{8'hFF, 1'b1, 2'd0, NO_RESULT, NO_RESULT};
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int texts;
        int random_sent;
        texts = 0;
        random_sent = 0;

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            send_item(plan[i]);

        while (random_sent < 300)
        begin
            gaps_on = !(texts >= 6 && texts < 12);
            if (texts == 4)
                drain_results();
            if (texts == 3)
            begin
                // Overflow the stack; everything after the overflow is ignored.
                text.delete();
                repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
                    text.push_back(bracket_char($urandom_range(0, 2)));
                repeat ($urandom_range(1, 5))
                    text.push_back(filler());
            end
            else if (texts == 9)
            begin
                // Full stack and an open string: the most results one byte can cause.
                text.delete();
                repeat (STACK_DEPTH)
                    text.push_back(bracket_char($urandom_range(0, 2)));
                text.push_back(CH_DQUOTE);
            end
            else
                compose_text($urandom_range(1, 14));
            send_text();
            random_sent += text.size();
            texts++;
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (2 * STACK_DEPTH + 10)
            @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, several times the slowest expected run.
    initial
    begin
        #6_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
